// ===== design/ccsc_pkg.sv =====
package ccsc_pkg;

   localparam int MAX_OBS_DEF    = 64;
   localparam int MAX_PARTS_DEF  = 128;
   localparam int LABEL_BITS_DEF = 12;

   localparam int VALUE_BITS     = 19;
   localparam int NUM_OBS_RESET   = 64;
   localparam int NUM_PARTS_RESET = 128;

   // request codes
   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_COMPUTE  = 2'd1;
   localparam logic [1:0] REQ_READ_SIM = 2'd2;
   localparam logic [1:0] REQ_READ_COST = 2'd3;

   // result codes
   localparam logic [1:0] KIND_DONE = 2'd0;
   localparam logic [1:0] KIND_SIM  = 2'd1;
   localparam logic [1:0] KIND_COST = 2'd2;

   // register indexes
   localparam logic CSR_NUM_OBS   = 1'b0;
   localparam logic CSR_NUM_PARTS = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] label;
      logic [5:0]  obs_a;
      logic [5:0]  obs_b;
      logic [6:0]  part_index;
   } req_word_type;

   typedef struct packed {
      logic [18:0] value;
      logic [1:0]  result_kind;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIAG,
      ST_COUNT,
      ST_COUNT_DRAIN,
      ST_PAIR_LO,
      ST_PAIR_HI,
      ST_ACCUM,
      ST_ACCUM_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== design/ccsc_label_mem.sv =====
module ccsc_label_mem import ccsc_pkg::*; #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = LABEL_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // write one label, read two rows' labels per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== design/coclustering_similarity_and_cost.sv =====
// Co-clustering similarity and cost engine.
// Request words (req_valid/req_ready) carry a request code and fields.
// A label load gives no response; loads may arrive one per cycle while the
// engine is idle. A similarity or cost read gives one response word
// (rsp_valid/rsp_ready) through ST_READ and the output register. A
// compute request walks the diagonal, then for each pair i<j runs a count
// pass, two pair-store writes and a cost pass. Its done word follows at
// the end. No other request is taken while compute or a read is in
// progress.
// The csr port writes num_obs and num_parts; write them only while idle.
// Reset returns to idle, restores the registers to 64 and 128 and marks
// all costs zero; label and pair stores hold whatever they held.
// A stalled response holds in the output register; loads continue to be
// taken while it waits, other requests wait until it is taken.
module coclustering_similarity_and_cost import ccsc_pkg::*; #(
   parameter int MAX_OBS    = MAX_OBS_DEF,
   parameter int MAX_PARTS  = MAX_PARTS_DEF,
   parameter int LABEL_BITS = LABEL_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int OBS_W  = $clog2(MAX_OBS);
   localparam int N_W    = $clog2(MAX_OBS + 1);
   localparam int PART_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNT_W  = $clog2(MAX_PARTS + 1);
   localparam int COST_W = 2 * OBS_W + CNT_W + 1;
   localparam int LADDR_W = OBS_W + PART_W;

   state_type state_ff, state_in;

   logic [6:0]       num_obs_ff;
   logic [7:0]       num_parts_ff;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [OBS_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PART_W-1:0] k_ff, k_in, kp_ff;
   logic             pipe_ff, pipe_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [1:0]       rd_kind_ff;
   logic             rd_ok_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             rsp_load;

   logic             accept;
   logic             rsp_free;
   logic [31:0]      a_ext, b_ext, part_ext, nobs_ext, nparts_ext;
   logic             a_ok, b_ok, part_ok;

   logic [LABEL_BITS-1:0] lab_a, lab_b;
   logic             lab_wr;
   logic             same;

   logic [CNT_W-1:0] pair_mem [2**(2*OBS_W)];
   logic [CNT_W-1:0] pair_rd_ff;
   logic             pair_wr;
   logic [2*OBS_W-1:0] pair_waddr;
   logic [CNT_W-1:0] pair_wdata;

   logic [COST_W-1:0] cost_mem [2**PART_W];
   logic [COST_W-1:0] cost_rd_ff;
   logic             cost_rd_vld_ff;
   logic             cost_vld_ff [MAX_PARTS];
   logic [PART_W-1:0] cost_raddr;
   logic             cost_wr;
   logic [COST_W-1:0] cost_wdata;
   logic             cost_clear;

   // decode request fields
   assign a_ext      = 32'(req_word.obs_a);
   assign b_ext      = 32'(req_word.obs_b);
   assign part_ext   = 32'(req_word.part_index);
   assign a_ok       = a_ext < 32'(MAX_OBS);
   assign b_ok       = b_ext < 32'(MAX_OBS);
   assign part_ok    = part_ext < 32'(MAX_PARTS);
   assign nobs_ext   = 32'(num_obs_ff);
   assign nparts_ext = 32'(num_parts_ff);

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) &&
                      (rsp_free || (req_word.req_type == REQ_LOAD));
   assign accept    = req_valid && req_ready;
   assign lab_wr    = accept && (req_word.req_type == REQ_LOAD) && a_ok && part_ok;
   assign same      = (lab_a == lab_b);

   ccsc_label_mem #(
      .ADDR_W (LADDR_W),
      .DATA_W (LABEL_BITS)
   ) u_label_mem (
      .clock     (clock),
      .wr_en     (lab_wr),
      .wr_addr   ({a_ext[OBS_W-1:0], part_ext[PART_W-1:0]}),
      .wr_data   (LABEL_BITS'(32'(req_word.label))),
      .rd_addr_a ({i_ff, k_ff}),
      .rd_addr_b ({j_ff, k_ff}),
      .rd_data_a (lab_a),
      .rd_data_b (lab_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_word.req_type)
                  REQ_LOAD:    state_in = ST_IDLE;
                  REQ_COMPUTE: state_in = ST_DIAG;
                  default:     state_in = ST_READ;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_DIAG: begin
            if ((N_W'(i_ff) + N_W'(1)) == n_ff) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if ((CNT_W'(k_ff) + CNT_W'(1)) == p_ff) state_in = ST_COUNT_DRAIN;
         end
         ST_COUNT_DRAIN: state_in = ST_PAIR_LO;
         ST_PAIR_LO:     state_in = ST_PAIR_HI;
         ST_PAIR_HI:     state_in = ST_ACCUM;
         ST_ACCUM: begin
            if ((CNT_W'(k_ff) + CNT_W'(1)) == p_ff) state_in = ST_ACCUM_DRAIN;
         end
         ST_ACCUM_DRAIN: begin
            if (((N_W'(j_ff) + N_W'(1)) == n_ff) && ((N_W'(i_ff) + N_W'(2)) == n_ff))
               state_in = ST_DONE;
            else
               state_in = ST_COUNT;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls and counter updates
   always_comb begin
      n_in        = n_ff;
      p_in        = p_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      pipe_in     = 1'b0;
      cnt_in      = cnt_ff;
      pair_wr     = 1'b0;
      pair_waddr  = {i_ff, j_ff};
      pair_wdata  = cnt_ff;
      cost_raddr  = k_ff;
      cost_wr     = 1'b0;
      cost_wdata  = (cost_rd_vld_ff ? cost_rd_ff : '0) +
                    (COST_W'(same ? (p_ff - cnt_ff) : cnt_ff) << 1);
      cost_clear  = 1'b0;
      rsp_load    = 1'b0;
      rsp_word_in = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cost_raddr = part_ext[PART_W-1:0];
            if (accept && (req_word.req_type == REQ_COMPUTE)) begin
               cost_clear = 1'b1;
               i_in = '0;
               k_in = '0;
               n_in = (nobs_ext < 32'd2) ? N_W'(2) :
                      (nobs_ext > 32'(MAX_OBS)) ? N_W'(MAX_OBS) : N_W'(nobs_ext);
               p_in = (nparts_ext < 32'd1) ? CNT_W'(1) :
                      (nparts_ext > 32'(MAX_PARTS)) ? CNT_W'(MAX_PARTS) :
                      CNT_W'(nparts_ext);
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            rsp_word_in.result_kind = rd_kind_ff;
            if (rd_kind_ff == KIND_SIM)
               rsp_word_in.value = rd_ok_ff ? VALUE_BITS'(32'(pair_rd_ff)) : '0;
            else
               rsp_word_in.value = (rd_ok_ff && cost_rd_vld_ff) ?
                                   VALUE_BITS'(32'(cost_rd_ff)) : '0;
         end
         ST_DIAG: begin
            pair_wr    = 1'b1;
            pair_waddr = {i_ff, i_ff};
            pair_wdata = p_ff;
            cnt_in     = '0;
            if ((N_W'(i_ff) + N_W'(1)) == n_ff) begin
               i_in = '0;
               j_in = OBS_W'(1);
            end else begin
               i_in = i_ff + OBS_W'(1);
            end
         end
         ST_COUNT: begin
            pipe_in = 1'b1;
            if ((CNT_W'(k_ff) + CNT_W'(1)) != p_ff) k_in = k_ff + PART_W'(1);
            if (pipe_ff && same) cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_COUNT_DRAIN: begin
            k_in = '0;
            if (pipe_ff && same) cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_PAIR_LO: begin
            pair_wr = 1'b1;
         end
         ST_PAIR_HI: begin
            pair_wr    = 1'b1;
            pair_waddr = {j_ff, i_ff};
         end
         ST_ACCUM: begin
            pipe_in = 1'b1;
            cost_wr = pipe_ff;
            if ((CNT_W'(k_ff) + CNT_W'(1)) != p_ff) k_in = k_ff + PART_W'(1);
         end
         ST_ACCUM_DRAIN: begin
            cost_wr = pipe_ff;
            k_in    = '0;
            cnt_in  = '0;
            if ((N_W'(j_ff) + N_W'(1)) == n_ff) begin
               i_in = i_ff + OBS_W'(1);
               j_in = OBS_W'(32'(i_ff) + 32'd2);
            end else begin
               j_in = j_ff + OBS_W'(1);
            end
         end
         ST_DONE: begin
            rsp_load = 1'b1;
            rsp_word_in.value = '0;
            rsp_word_in.result_kind = KIND_DONE;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_obs_ff   <= 7'(NUM_OBS_RESET);
         num_parts_ff <= 8'(NUM_PARTS_RESET);
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pipe_ff  <= pipe_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_NUM_OBS:   num_obs_ff   <= csr_wdata[6:0];
               CSR_NUM_PARTS: num_parts_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer payload registers
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      p_ff   <= p_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      kp_ff  <= k_ff;
      cnt_ff <= cnt_in;
      if (rsp_load) rsp_word_ff <= rsp_word_in;
      if (accept) begin
         rd_kind_ff <= (req_word.req_type == REQ_READ_SIM) ? KIND_SIM : KIND_COST;
         rd_ok_ff   <= (req_word.req_type == REQ_READ_SIM) ? (a_ok && b_ok) : part_ok;
      end
   end

   // pair count store
   always_ff @(posedge clock) begin
      if (pair_wr) pair_mem[pair_waddr] <= pair_wdata;
      pair_rd_ff <= pair_mem[{a_ext[OBS_W-1:0], b_ext[OBS_W-1:0]}];
   end

   // cost store, read-modify-write one partition per cycle
   always_ff @(posedge clock) begin
      if (cost_wr) cost_mem[kp_ff] <= cost_wdata;
      cost_rd_ff <= cost_mem[cost_raddr];
   end

   // cost valid bits: unwritten costs read as zero
   always_ff @(posedge clock) begin
      if (reset || cost_clear) begin
         for (int q = 0; q < MAX_PARTS; q++) cost_vld_ff[q] <= 1'b0;
         cost_rd_vld_ff <= 1'b0;
      end else begin
         if (cost_wr) cost_vld_ff[kp_ff] <= 1'b1;
         cost_rd_vld_ff <= (32'(cost_raddr) < 32'(MAX_PARTS)) ?
                           cost_vld_ff[cost_raddr] : 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
